// ----- sv/bafc_pkg.sv -----
// Shared types, register indexes and constants for the box-average false-color block.
// Used by bafc_datapath, bafc_ctrl and the top level; depends on nothing.
`default_nettype none

package bafc_pkg;

  // Configuration port geometry.
  localparam int CFG_W  = 16;
  localparam int APER_W = 5;
  localparam int IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_TEMP_MIN     = 3'd0;
  localparam logic [IDX_W-1:0] REG_TEMP_MAX     = 3'd1;
  localparam logic [IDX_W-1:0] REG_AMBIENT_TEMP = 3'd2;
  localparam logic [IDX_W-1:0] REG_HOTTEST_TEMP = 3'd3;
  localparam logic [IDX_W-1:0] REG_SPAN_TEMP    = 3'd4;
  localparam logic [IDX_W-1:0] REG_NULL_TEMP    = 3'd5;
  localparam logic [IDX_W-1:0] REG_APERTURE     = 3'd6;

  // Register values after reset.
  localparam logic signed [CFG_W-1:0] RST_TEMP_MIN     = 16'sd0;
  localparam logic signed [CFG_W-1:0] RST_TEMP_MAX     = 16'sd255;
  localparam logic signed [CFG_W-1:0] RST_AMBIENT_TEMP = 16'sd0;
  localparam logic signed [CFG_W-1:0] RST_HOTTEST_TEMP = 16'sd255;
  localparam logic        [CFG_W-1:0] RST_SPAN_TEMP    = 16'd255;
  localparam logic signed [CFG_W-1:0] RST_NULL_TEMP    = -16'sd459;
  localparam logic       [APER_W-1:0] RST_APERTURE     = 5'd1;

  // Default parameter values for the top level.
  localparam int MAX_APERTURE_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 16;

  // Hue scale: Q3.8, full scale 4.0 (1024), fraction scaled by 256.
  localparam int               HUE_W      = 11;
  localparam int               FRAC_SHIFT = 10;
  localparam logic [HUE_W-1:0] HUE_FULL   = 11'd1024;
  localparam int               COLOR_W    = 8;
  localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc_en;     // accumulate the accepted item
    logic avg_start;  // start the average division
    logic avg_load;   // capture the floor average
    logic hue_start;  // clamp, flag, and start the hue division
    logic out_load;   // load the output register with the pixel
  } bafc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic blk_done;   // this item completes a block
    logic div_done;   // divider finished this cycle
  } bafc_sts_t;

endpackage

`default_nettype wire

// ----- sv/bafc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on nothing; used by bafc_datapath for both the average and the hue.
`default_nettype none

module bafc_div #(
  parameter int DVD_W = 26,
  parameter int DVS_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quot,
  output logic      [DVS_W-1:0] rem
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quot_r, quot_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One trial subtraction of the shifted partial remainder.
  assign rem_sh = {rem_r, quot_r[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = ~diff[DVS_W];

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(DVD_W);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      quot_nxt = {quot_r[DVD_W-2:0], ge};
      rem_nxt  = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; operands are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- sv/bafc_datapath.sv -----
// Datapath: configuration registers, block accumulator, shared divider, hue and color.
// Depends on bafc_pkg and bafc_div; driven by commands from bafc_ctrl.
`default_nettype none

module bafc_datapath
  import bafc_pkg::*;
#(
  parameter int MAX_APERTURE = MAX_APERTURE_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic              [IDX_W-1:0] cfg_index,
  input  wire logic              [CFG_W-1:0] cfg_wdata,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_temp,
  input  wire bafc_cmd_t                     cmd,
  output bafc_sts_t                          sts,
  output logic                 [COLOR_W-1:0] out_red,
  output logic                 [COLOR_W-1:0] out_green,
  output logic                 [COLOR_W-1:0] out_blue,
  output logic signed            [CFG_W-1:0] out_avg_temp,
  output logic                               out_out_of_range
);

  localparam int VAL_W = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
  localparam int CNT_W = $clog2(MAX_APERTURE * MAX_APERTURE + 1);
  localparam int SUM_W = VAL_W + CNT_W;
  localparam int HDV_W = VAL_W + FRAC_SHIFT;
  localparam int DVD_W = (SUM_W > HDV_W) ? SUM_W : HDV_W;
  localparam int DVS_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int APW   = $clog2(MAX_APERTURE + 1);
  localparam int EW    = (APW > APER_W) ? APW : APER_W;

  // Configuration registers.
  logic signed [CFG_W-1:0] temp_min_r, temp_max_r, ambient_r, hottest_r, null_r;
  logic        [CFG_W-1:0] span_r;
  logic       [APER_W-1:0] aperture_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_min_r <= RST_TEMP_MIN;
      temp_max_r <= RST_TEMP_MAX;
      ambient_r  <= RST_AMBIENT_TEMP;
      hottest_r  <= RST_HOTTEST_TEMP;
      span_r     <= RST_SPAN_TEMP;
      null_r     <= RST_NULL_TEMP;
      aperture_r <= RST_APERTURE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_MIN:     temp_min_r <= cfg_wdata;
        REG_TEMP_MAX:     temp_max_r <= cfg_wdata;
        REG_AMBIENT_TEMP: ambient_r  <= cfg_wdata;
        REG_HOTTEST_TEMP: hottest_r  <= cfg_wdata;
        REG_SPAN_TEMP:    span_r     <= cfg_wdata;
        REG_NULL_TEMP:    null_r     <= cfg_wdata;
        REG_APERTURE:     aperture_r <= cfg_wdata[APER_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective aperture, bounded to 1..MAX_APERTURE, and the block size it needs.
  logic [EW-1:0]   ap_ext, ap_eff;
  logic [2*EW-1:0] need;

  assign ap_ext = EW'(aperture_r);
  always_comb begin
    if (ap_ext == '0) begin
      ap_eff = EW'(1);
    end else if (ap_ext > EW'(MAX_APERTURE)) begin
      ap_eff = EW'(MAX_APERTURE);
    end else begin
      ap_eff = ap_ext;
    end
  end
  assign need = (2*EW)'(ap_eff) * (2*EW)'(ap_eff);

  // Accumulator: each sample is raised to temp_min and added to the block sum.
  logic signed [VAL_W-1:0] samp_ext, tmin_ext, samp_clamp;
  logic signed [SUM_W-1:0] sum_r, sum_nxt, fin_sum_r;
  logic        [CNT_W-1:0] count_r, count_nxt, fin_cnt_r;

  assign samp_ext   = VAL_W'(in_sample_temp);
  assign tmin_ext   = VAL_W'(temp_min_r);
  assign samp_clamp = (samp_ext < tmin_ext) ? tmin_ext : samp_ext;
  assign sum_nxt    = sum_r + SUM_W'(samp_clamp);
  assign count_nxt  = count_r + CNT_W'(1);
  assign sts.blk_done = ((2*EW)'(count_nxt) >= need);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else if (cmd.acc_en) begin
      if (sts.blk_done) begin
        sum_r   <= '0;
        count_r <= '0;
      end else begin
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // The finished block is held while the divider works on it.
  always_ff @(posedge clk) begin
    if (cmd.acc_en && sts.blk_done) begin
      fin_sum_r <= sum_nxt;
      fin_cnt_r <= count_nxt;
    end
  end

  // Hue operands: clamp the average into the ambient..hottest band.
  logic signed [VAL_W-1:0] avg_r, amb_ext, hot_ext, tmax_ext, null_ext, t_clamp;
  logic signed   [VAL_W:0] d_val;
  logic                    d_pos;

  assign amb_ext  = VAL_W'(ambient_r);
  assign hot_ext  = VAL_W'(hottest_r);
  assign tmax_ext = VAL_W'(temp_max_r);
  assign null_ext = VAL_W'(null_r);

  always_comb begin
    if (avg_r < amb_ext) begin
      t_clamp = amb_ext;
    end else if (avg_r > hot_ext) begin
      t_clamp = hot_ext;
    end else begin
      t_clamp = avg_r;
    end
  end
  assign d_val = (VAL_W+1)'(t_clamp) - (VAL_W+1)'(amb_ext);
  assign d_pos = !d_val[VAL_W] && (d_val != '0);

  // Shared divider: floor average first, then the hue quotient.
  logic [SUM_W-1:0] sum_mag;
  logic [DVD_W-1:0] div_dvd, div_quot;
  logic [DVS_W-1:0] div_dvs, div_rem;
  logic             div_start;

  assign sum_mag   = fin_sum_r[SUM_W-1] ? SUM_W'(-fin_sum_r) : SUM_W'(fin_sum_r);
  assign div_start = cmd.avg_start | cmd.hue_start;

  always_comb begin
    if (cmd.hue_start) begin
      div_dvd = d_pos ? DVD_W'({d_val[VAL_W-1:0], {FRAC_SHIFT{1'b0}}}) : '0;
      div_dvs = (span_r == '0) ? DVS_W'(1) : DVS_W'(span_r);
    end else begin
      div_dvd = DVD_W'(sum_mag);
      div_dvs = DVS_W'(fin_cnt_r);
    end
  end

  bafc_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (sts.div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Floor average: a negative sum with a remainder rounds one further down.
  logic [DVD_W:0] q_up, avg_full;

  assign q_up = {1'b0, div_quot} + (DVD_W+1)'(div_rem != '0);
  assign avg_full = fin_sum_r[SUM_W-1] ? -q_up : {1'b0, div_quot};

  always_ff @(posedge clk) begin
    if (cmd.avg_load) begin
      avg_r <= avg_full[VAL_W-1:0];
    end
  end

  // Flags taken when the hue division starts.
  logic oor_r, blank_r, dpos_r;

  always_ff @(posedge clk) begin
    if (cmd.hue_start) begin
      oor_r   <= (avg_r > tmax_ext);
      blank_r <= (avg_r == null_ext);
      dpos_r  <= d_pos;
    end
  end

  // Hue in Q3.8, saturated to 0..4.0, then the five-segment rainbow.
  logic [HUE_W-1:0]   hue;
  logic [COLOR_W-1:0] frac, r_c, g_c, b_c;

  always_comb begin
    if (!dpos_r) begin
      hue = HUE_FULL;
    end else if (div_quot > DVD_W'(HUE_FULL)) begin
      hue = '0;
    end else begin
      hue = HUE_FULL - div_quot[HUE_W-1:0];
    end
  end
  assign frac = hue[COLOR_W-1:0];

  always_comb begin
    unique case (hue[HUE_W-1:COLOR_W])
      3'd1: begin
        r_c = COLOR_MAX - frac; g_c = COLOR_MAX; b_c = '0;
      end
      3'd2: begin
        r_c = '0; g_c = COLOR_MAX; b_c = frac;
      end
      3'd3: begin
        r_c = '0; g_c = COLOR_MAX - frac; b_c = COLOR_MAX;
      end
      3'd4: begin
        r_c = frac; g_c = '0; b_c = COLOR_MAX;
      end
      default: begin
        r_c = COLOR_MAX; g_c = frac; b_c = '0;
      end
    endcase
  end

  // Output register; out-of-range and sentinel averages are shown black.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_red          <= (oor_r || blank_r) ? '0 : r_c;
      out_green        <= (oor_r || blank_r) ? '0 : g_c;
      out_blue         <= (oor_r || blank_r) ? '0 : b_c;
      out_avg_temp     <= avg_r[CFG_W-1:0];
      out_out_of_range <= oor_r;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bafc_ctrl.sv -----
// Controller state machine: handshakes, sequencing of the two divisions, output valid.
// Depends on bafc_pkg; drives bafc_datapath through command and status structs.
`default_nettype none

module bafc_ctrl
  import bafc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire bafc_sts_t sts,
  output bafc_cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_AVG_GO   = 6'b000010,
    S_AVG_WAIT = 6'b000100,
    S_HUE_GO   = 6'b001000,
    S_HUE_WAIT = 6'b010000,
    S_EMIT     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Sequencing: accumulate, divide for the average, divide for the hue, emit.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.acc_en    = accept;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (accept && sts.blk_done) begin
          state_nxt = S_AVG_GO;
        end
      end
      S_AVG_GO: begin
        cmd.avg_start = 1'b1;
        state_nxt     = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (sts.div_done) begin
          cmd.avg_load = 1'b1;
          state_nxt    = S_HUE_GO;
        end
      end
      S_HUE_GO: begin
        cmd.hue_start = 1'b1;
        state_nxt     = S_HUE_WAIT;
      end
      S_HUE_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- sv/box_average_false_color.sv -----
// Box-average false-color block: averages aperture-squared samples into one colored pixel.
// An item that does not close a block is accepted without a stall. An item that closes a block keeps
// the input stalled while the shared divider, one quotient bit per cycle, forms the floor average
// and then the hue, and longer while the previous pixel is not yet taken.
// The pixel waits in an output register, so input is taken again while it is pending.
// Synchronous active-low reset clears the accumulator and the output valid and loads the configuration reset values.
`default_nettype none

module box_average_false_color
  import bafc_pkg::*;
#(
  parameter int MAX_APERTURE = MAX_APERTURE_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic              [IDX_W-1:0] cfg_index,
  input  wire logic              [CFG_W-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_temp,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                 [COLOR_W-1:0] out_red,
  output logic                 [COLOR_W-1:0] out_green,
  output logic                 [COLOR_W-1:0] out_blue,
  output logic signed            [CFG_W-1:0] out_avg_temp,
  output logic                               out_out_of_range
);

  bafc_cmd_t cmd;
  bafc_sts_t sts;

  // Sequencer.
  bafc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  bafc_datapath #(
    .MAX_APERTURE (MAX_APERTURE),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_sample_temp   (in_sample_temp),
    .cmd              (cmd),
    .sts              (sts),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_avg_temp     (out_avg_temp),
    .out_out_of_range (out_out_of_range)
  );

endmodule

`default_nettype wire
